// File: src/tgi_pkg.sv
// shared types and constants of the trilinear grid interpolator
`timescale 1ns / 1ps
package tgi_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [2:0] SUM_SELECT = 3'd5;

  localparam logic [2:0] CFG_ALPHA_ORIGIN   = 3'd0;
  localparam logic [2:0] CFG_ALPHA_INV_STEP = 3'd1;
  localparam logic [2:0] CFG_K_ORIGIN       = 3'd2;
  localparam logic [2:0] CFG_K_INV_STEP     = 3'd3;
  localparam logic [2:0] CFG_R_ORIGIN       = 3'd4;
  localparam logic [2:0] CFG_R_INV_STEP     = 3'd5;

  localparam int OUT_DEPTH = 16;
  localparam int OUT_PW    = 4;

  typedef struct packed {
    logic               operation;
    logic [2:0]         table_select;
    logic signed [31:0] alpha_coord;
    logic signed [31:0] k_coord;
    logic signed [31:0] r_coord;
    logic [3:0]         load_alpha_index;
    logic [3:0]         load_k_index;
    logic [3:0]         load_r_index;
    logic signed [31:0] load_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] interpolated_value;
    logic               out_of_grid;
  } out_t;

endpackage

// File: src/tgi_axis.sv
// per-axis locate pipeline: offset, scale, cell index and weight
`timescale 1ns / 1ps
module tgi_axis #(
  parameter int INTERVALS = 15,
  parameter int IW        = $clog2(INTERVALS + 1)
) (
  input  logic              clk_i,
  input  logic signed [31:0] coord_i,
  input  logic signed [31:0] origin_i,
  input  logic [31:0]       inv_i,
  output logic [IW-1:0]     lo_o,
  output logic [IW-1:0]     hi_o,
  output logic [15:0]       w_o,
  output logic              oog_o
);

  logic [32:0] off_q;
  logic [63:0] p_q;
  logic        neg_oog_q;
  logic [31:0] mag;
  logic [31:0] ipart;
  logic        last;

  assign mag   = off_q[32] ? '0 : off_q[31:0];
  assign ipart = p_q[63:32];
  assign last  = (ipart == 32'(INTERVALS));

  always_ff @(posedge clk_i) begin
    off_q     <= {coord_i[31], coord_i} - {origin_i[31], origin_i};
    p_q       <= {32'd0, mag} * {32'd0, inv_i};
    neg_oog_q <= off_q[32] & (inv_i != '0);
    oog_o     <= neg_oog_q | (ipart > 32'(INTERVALS));
    lo_o      <= IW'(ipart);
    hi_o      <= last ? IW'(ipart) : IW'(ipart + 32'd1);
    w_o       <= last ? '0 : p_q[31:16];
  end

endmodule

// File: src/tgi_bank.sv
// one sample bank: one write port, two registered read ports
`timescale 1ns / 1ps
module tgi_bank #(
  parameter int AW    = 12,
  parameter int DEPTH = 2560
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic signed [31:0] wdata_i,
  input  logic [AW-1:0]     raddr_a_i,
  input  logic [AW-1:0]     raddr_b_i,
  output logic signed [31:0] rdata_a_o,
  output logic signed [31:0] rdata_b_o
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// File: src/tgi_blend.sv
// two-stage linear blend with round half up
`timescale 1ns / 1ps
module tgi_blend (
  input  logic              clk_i,
  input  logic signed [31:0] lo_i,
  input  logic signed [31:0] hi_i,
  input  logic [15:0]       w_i,
  output logic signed [31:0] y_o
);

  logic signed [32:0] diff;
  logic signed [49:0] prod_q;
  logic signed [31:0] lo_q;
  logic signed [49:0] acc;

  // zero weight keeps the lower sample and ignores the upper one
  assign diff = (w_i == '0) ? '0 : 33'(hi_i) - 33'(lo_i);
  assign acc  = 50'(lo_q) + ((prod_q + 50'sd32768) >>> 16);

  always_ff @(posedge clk_i) begin
    prod_q <= diff * $signed({1'b0, w_i});
    lo_q   <= lo_i;
    y_o    <= acc[31:0];
  end

endmodule

// File: src/tgi_fifo.sv
// result queue between the pipeline and the output channel
`timescale 1ns / 1ps
module tgi_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tgi_pkg::out_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output tgi_pkg::out_t data_o
);
  import tgi_pkg::*;

  out_t              entry_q [OUT_DEPTH];
  logic [OUT_PW-1:0] wr_q, wr_d;
  logic [OUT_PW-1:0] rd_q, rd_d;
  logic [OUT_PW:0]   cnt_q, cnt_d;
  logic              pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rd_q];
  assign pop     = valid_o & ready_i;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (OUT_PW + 1)'(push_i) - (OUT_PW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= data_i;
    end
  end

endmodule

// File: src/trilinear_grid_interpolator_unit.sv
// top level of the trilinear grid interpolator
`timescale 1ns / 1ps
// Takes one beat per cycle, loads and queries alike, sum select included: the samples sit in
// eight banks split by the parity of each grid index, each bank with two read ports, so all
// eight corners of one table (port a) and of table 1 (port b) are read together. A query
// passes stages s1..s10 and then the output queue; a load writes its bank in stage s3, the same
// stage where queries read, so order is kept. Up to 16 queries may be in flight or waiting in
// the output queue; with the output stalled the input stops there.
// The sample store has no clearing pass: read only entries that were loaded.
module trilinear_grid_interpolator_unit #(
  parameter int ALPHA_INTERVALS = 15,
  parameter int K_INTERVALS     = 15,
  parameter int R_INTERVALS     = 15,
  parameter int TABLE_COUNT     = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tgi_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tgi_pkg::out_t out_o
);
  import tgi_pkg::*;

  localparam int AIW = $clog2(ALPHA_INTERVALS + 1);
  localparam int KIW = $clog2(K_INTERVALS + 1);
  localparam int RIW = $clog2(R_INTERVALS + 1);
  localparam int HA  = (ALPHA_INTERVALS + 2) / 2;
  localparam int HK  = (K_INTERVALS + 2) / 2;
  localparam int HR  = (R_INTERVALS + 2) / 2;
  localparam int BD  = TABLE_COUNT * HA * HK * HR;
  localparam int BAW = $clog2(BD);
  localparam int CW  = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic               op;
    logic [2:0]         sel;
    logic [3:0]         la;
    logic [3:0]         lk;
    logic [3:0]         lr;
    logic signed [31:0] lval;
  } ctrl_t;

  typedef struct packed {
    logic        unknown;
    logic        oog;
    logic        sum;
    logic [2:0]  par;
    logic [15:0] w_r;
    logic [15:0] w_k;
    logic [15:0] w_a;
  } meta_t;

  function automatic logic [BAW-1:0] baddr(input logic [31:0] t, input logic [31:0] ha,
                                           input logic [31:0] hk, input logic [31:0] hr);
    logic [31:0] lin;
    lin = ((t * 32'(HA) + ha) * 32'(HK) + hk) * 32'(HR) + hr;
    return lin[BAW-1:0];
  endfunction

  // configuration
  logic signed [31:0] a_org_q, k_org_q, r_org_q;
  logic [31:0]        a_inv_q, k_inv_q, r_inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_org_q <= '0;
      a_inv_q <= 32'd65536;
      k_org_q <= '0;
      k_inv_q <= 32'd65536;
      r_org_q <= '0;
      r_inv_q <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALPHA_ORIGIN:   a_org_q <= cfg_data_i;
        CFG_ALPHA_INV_STEP: a_inv_q <= cfg_data_i;
        CFG_K_ORIGIN:       k_org_q <= cfg_data_i;
        CFG_K_INV_STEP:     k_inv_q <= cfg_data_i;
        CFG_R_ORIGIN:       r_org_q <= cfg_data_i;
        CFG_R_INV_STEP:     r_inv_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // credit for queries in flight or queued
  logic          in_fire, out_fire, q_in;
  logic [CW-1:0] credit_q, credit_d;

  assign in_ready_o = (credit_q < CW'(OUT_DEPTH));
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_fire   = out_valid_o & out_ready_i;
  assign q_in       = in_fire & (in_i.operation == OP_QUERY);
  assign credit_d   = credit_q + CW'(q_in) - CW'(out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_d;
    end
  end

  // front stages s1..s3
  ctrl_t      front_q [3];
  logic [2:0] fv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else begin
      fv_q <= {fv_q[1:0], in_fire};
    end
  end

  always_ff @(posedge clk_i) begin
    front_q[0] <= '{op: in_i.operation, sel: in_i.table_select, la: in_i.load_alpha_index,
                    lk: in_i.load_k_index, lr: in_i.load_r_index, lval: in_i.load_value};
    for (int i = 1; i < 3; i++) begin
      front_q[i] <= front_q[i-1];
    end
  end

  logic [AIW-1:0] lo_a, hi_a;
  logic [KIW-1:0] lo_k, hi_k;
  logic [RIW-1:0] lo_r, hi_r;
  logic [15:0]    w_a, w_k, w_r;
  logic           oog_a, oog_k, oog_r;

  tgi_axis #(.INTERVALS(ALPHA_INTERVALS), .IW(AIW)) u_axis_a (
    .clk_i, .coord_i(in_i.alpha_coord), .origin_i(a_org_q), .inv_i(a_inv_q),
    .lo_o(lo_a), .hi_o(hi_a), .w_o(w_a), .oog_o(oog_a)
  );
  tgi_axis #(.INTERVALS(K_INTERVALS), .IW(KIW)) u_axis_k (
    .clk_i, .coord_i(in_i.k_coord), .origin_i(k_org_q), .inv_i(k_inv_q),
    .lo_o(lo_k), .hi_o(hi_k), .w_o(w_k), .oog_o(oog_k)
  );
  tgi_axis #(.INTERVALS(R_INTERVALS), .IW(RIW)) u_axis_r (
    .clk_i, .coord_i(in_i.r_coord), .origin_i(r_org_q), .inv_i(r_inv_q),
    .lo_o(lo_r), .hi_o(hi_r), .w_o(w_r), .oog_o(oog_r)
  );

  // s3: bank access
  ctrl_t          c3;
  logic           v3, ld_ok;
  logic [AIW-1:0] wa_idx;
  logic [KIW-1:0] wk_idx;
  logic [RIW-1:0] wr_idx;
  logic [2:0]     wbank;
  logic [BAW-1:0] waddr;
  logic [31:0]    tsel_a;

  assign c3     = front_q[2];
  assign v3     = fv_q[2];
  assign wa_idx = AIW'(c3.la);
  assign wk_idx = KIW'(c3.lk);
  assign wr_idx = RIW'(c3.lr);
  assign wbank  = {wa_idx[0], wk_idx[0], wr_idx[0]};
  assign ld_ok  = v3 & (c3.op == OP_LOAD) & (32'(c3.sel) < 32'(TABLE_COUNT)) &
                  (32'(c3.la) <= 32'(ALPHA_INTERVALS)) & (32'(c3.lk) <= 32'(K_INTERVALS)) &
                  (32'(c3.lr) <= 32'(R_INTERVALS));
  assign waddr  = baddr(32'(c3.sel), 32'(wa_idx >> 1), 32'(wk_idx >> 1), 32'(wr_idx >> 1));
  assign tsel_a = (c3.sel == SUM_SELECT) ? 32'd0 : 32'(c3.sel);

  logic signed [31:0] rd_a [8];
  logic signed [31:0] rd_b [8];

  for (genvar b = 0; b < 8; b++) begin : g_bank
    localparam logic PA = 1'((b >> 2) & 1);
    localparam logic PK = 1'((b >> 1) & 1);
    localparam logic PR = 1'(b & 1);
    logic [AIW-1:0] ia;
    logic [KIW-1:0] ik;
    logic [RIW-1:0] ir;
    logic [BAW-1:0] ra, rb;

    assign ia = (lo_a[0] == PA) ? lo_a : hi_a;
    assign ik = (lo_k[0] == PK) ? lo_k : hi_k;
    assign ir = (lo_r[0] == PR) ? lo_r : hi_r;
    assign ra = baddr(tsel_a, 32'(ia >> 1), 32'(ik >> 1), 32'(ir >> 1));
    assign rb = baddr(32'd1, 32'(ia >> 1), 32'(ik >> 1), 32'(ir >> 1));

    tgi_bank #(.AW(BAW), .DEPTH(BD)) u_bank (
      .clk_i,
      .we_i      (ld_ok && (wbank == 3'(b))),
      .waddr_i   (waddr),
      .wdata_i   (c3.lval),
      .raddr_a_i (ra),
      .raddr_b_i (rb),
      .rdata_a_o (rd_a[b]),
      .rdata_b_o (rd_b[b])
    );
  end

  // back stages s4..s10
  meta_t      meta_d;
  meta_t      meta_q [7];
  logic [6:0] bv_q;

  always_comb begin
    meta_d.unknown = !((c3.sel == SUM_SELECT) || (32'(c3.sel) < 32'(TABLE_COUNT)));
    meta_d.oog     = oog_a | oog_k | oog_r;
    meta_d.sum     = (c3.sel == SUM_SELECT);
    meta_d.par     = {lo_a[0], lo_k[0], lo_r[0]};
    meta_d.w_r     = w_r;
    meta_d.w_k     = w_k;
    meta_d.w_a     = w_a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
    end else begin
      bv_q <= {bv_q[5:0], v3 & (c3.op == OP_QUERY)};
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q[0] <= meta_d;
    for (int i = 1; i < 7; i++) begin
      meta_q[i] <= meta_q[i-1];
    end
  end

  // corner c = {da, dk, dr} sits in the bank whose parity is lo parity xor c
  logic signed [31:0] cor [2][8];
  logic signed [31:0] vr  [2][4];
  logic signed [31:0] vk  [2][2];
  logic signed [31:0] va  [2];

  for (genvar c = 0; c < 8; c++) begin : g_cor
    assign cor[0][c] = rd_a[3'(c) ^ meta_q[0].par];
    assign cor[1][c] = rd_b[3'(c) ^ meta_q[0].par];
  end

  for (genvar t = 0; t < 2; t++) begin : g_tab
    for (genvar j = 0; j < 4; j++) begin : g_r
      tgi_blend u_blend_r (
        .clk_i, .lo_i(cor[t][2*j]), .hi_i(cor[t][2*j+1]), .w_i(meta_q[0].w_r),
        .y_o(vr[t][j])
      );
    end
    for (genvar j = 0; j < 2; j++) begin : g_k
      tgi_blend u_blend_k (
        .clk_i, .lo_i(vr[t][2*j]), .hi_i(vr[t][2*j+1]), .w_i(meta_q[2].w_k),
        .y_o(vk[t][j])
      );
    end
    tgi_blend u_blend_a (
      .clk_i, .lo_i(vk[t][0]), .hi_i(vk[t][1]), .w_i(meta_q[4].w_a), .y_o(va[t])
    );
  end

  // s10: result select and saturation
  meta_t              m10;
  logic [32:0]        sum33;
  logic signed [31:0] sat;
  out_t               res;

  assign m10   = meta_q[6];
  assign sum33 = 33'(va[0]) + 33'(va[1]);

  always_comb begin
    if (sum33[32] != sum33[31]) begin
      sat = sum33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat = sum33[31:0];
    end
    res.out_of_grid = !m10.unknown & m10.oog;
    if (m10.unknown || m10.oog) begin
      res.interpolated_value = '0;
    end else if (m10.sum) begin
      res.interpolated_value = sat;
    end else begin
      res.interpolated_value = va[0];
    end
  end

  tgi_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (bv_q[6]),
    .data_i  (res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_o)
  );

endmodule

// File: src/tgi_checker.sv
// port-level checks of the interpolator and their binding
`timescale 1ns / 1ps
module tgi_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input tgi_pkg::out_t out_o
);
  import tgi_pkg::*;

  // a waiting result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_o))
    else $error("result beat changed while stalled");

  // out of grid always carries a zero value
  a_oog_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.out_of_grid |-> out_o.interpolated_value == '0)
    else $error("out of grid with nonzero value");

  // nothing to deliver straight after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result beat right after reset");

endmodule

bind trilinear_grid_interpolator_unit tgi_checker u_tgi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

// File: tb/sv/trilinear_grid_interpolator_unit_test.sv
// directed and random test of the trilinear grid interpolator against a predictor
`timescale 1ns / 1ps
module trilinear_grid_interpolator_unit_test;
  import tgi_pkg::*;

  localparam int INTERVALS   = 15;
  localparam int POINTS      = INTERVALS + 1;
  localparam int TABLE_SIZE  = POINTS * POINTS * POINTS;
  localparam int TABLES      = 5;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {SEL_UNKNOWN, SEL_OUTSIDE, SEL_INSIDE} locate_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  out_t        out_o;

  trilinear_grid_interpolator_unit u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_i, .out_valid_o, .out_ready_i, .out_o
  );

  logic [31:0] grid_reg [6];
  logic [31:0] sample_mem [TABLES*TABLE_SIZE];
  bit          loaded [TABLES*TABLE_SIZE];
  out_t        pending_results [$];
  int          errors = 0;
  int          cycles = 0;
  int          beats_sent = 0;
  bit          idling = 1'b1;
  bit          hold_req = 1'b0;

  initial forever #6 clk_i = ~clk_i;

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver side
  initial forever begin
    @(posedge clk_i);
    if (hold_req) begin
      out_ready_i <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_req = 1'b0;
      out_ready_i <= 1'b1;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual %h/%b", $time,
                 out_o.interpolated_value, out_o.out_of_grid);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_o.interpolated_value !== want.interpolated_value) begin
          $display("%0t interpolated_value: expected %h, actual %h", $time,
                   want.interpolated_value, out_o.interpolated_value);
          errors++;
        end
        if (out_o.out_of_grid !== want.out_of_grid) begin
          $display("%0t out_of_grid: expected %b, actual %b", $time,
                   want.out_of_grid, out_o.out_of_grid);
          errors++;
        end
      end
    end
  end

  function automatic int addr_of(int t, int a, int k, int r);
    return t * TABLE_SIZE + (a * POINTS + k) * POINTS + r;
  endfunction

  function automatic bit axis_cell(logic signed [31:0] c, logic signed [31:0] o,
                                   logic [31:0] inv, output int idx, output longint w);
    longint      off;
    logic [63:0] p;
    off = longint'(c) - longint'(o);
    idx = 0;
    w = 0;
    if (off < 0) begin
      if (inv != 0) return 1'b0;
      off = 0;
    end
    p = 64'(off) * {32'd0, inv};
    if (p[63:32] > INTERVALS) return 1'b0;
    idx = int'(p[63:32]);
    w = (idx == INTERVALS) ? 0 : longint'(p[31:16]);
    return 1'b1;
  endfunction

  function automatic locate_e locate(in_t it, output int lo[3], output int hi[3],
                                     output longint w[3]);
    logic signed [31:0] c [3];
    c[0] = it.alpha_coord;
    c[1] = it.k_coord;
    c[2] = it.r_coord;
    for (int i = 0; i < 3; i++) begin
      lo[i] = 0;
      hi[i] = 0;
      w[i] = 0;
    end
    if (!(it.table_select == SUM_SELECT || it.table_select < TABLES)) return SEL_UNKNOWN;
    for (int i = 0; i < 3; i++) begin
      if (!axis_cell(c[i], grid_reg[2*i], grid_reg[2*i+1], lo[i], w[i])) return SEL_OUTSIDE;
      hi[i] = (lo[i] < INTERVALS) ? lo[i] + 1 : lo[i];
    end
    return SEL_INSIDE;
  endfunction

  function automatic longint lerp(longint lo, longint hi, longint w);
    longint s;
    s = lo * (65536 - w) + hi * w + 32768;
    return s >>> 16;
  endfunction

  function automatic longint sample(int t, int a, int k, int r);
    return longint'($signed(sample_mem[addr_of(t, a, k, r)]));
  endfunction

  function automatic longint blend_table(int t, int lo[3], int hi[3], longint w[3]);
    longint kv [2];
    longint av [2];
    int     a, k;
    for (int da = 0; da < 2; da++) begin
      a = da ? hi[0] : lo[0];
      for (int dk = 0; dk < 2; dk++) begin
        k = dk ? hi[1] : lo[1];
        kv[dk] = lerp(sample(t, a, k, lo[2]), sample(t, a, k, hi[2]), w[2]);
      end
      av[da] = lerp(kv[0], kv[1], w[1]);
    end
    return lerp(av[0], av[1], w[0]);
  endfunction

  function automatic bit corners_loaded(in_t it);
    int      lo [3], hi [3];
    longint  w [3];
    int      t0, t1;
    if (it.operation == OP_LOAD) return 1'b1;
    if (locate(it, lo, hi, w) != SEL_INSIDE) return 1'b1;
    t0 = (it.table_select == SUM_SELECT) ? 0 : int'(it.table_select);
    t1 = (it.table_select == SUM_SELECT) ? 1 : t0;
    for (int n = 0; n < 8; n++) begin
      int a, k, r;
      a = n[2] ? hi[0] : lo[0];
      k = n[1] ? hi[1] : lo[1];
      r = n[0] ? hi[2] : lo[2];
      if (!loaded[addr_of(t0, a, k, r)] || !loaded[addr_of(t1, a, k, r)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic apply_item(in_t it);
    int      lo [3], hi [3];
    longint  w [3], v;
    out_t    res;
    int      ad;
    if (it.operation == OP_LOAD) begin
      if (it.table_select < TABLES) begin
        ad = addr_of(it.table_select, it.load_alpha_index, it.load_k_index, it.load_r_index);
        sample_mem[ad] = it.load_value;
        loaded[ad] = 1'b1;
      end
      return;
    end
    res = '0;
    case (locate(it, lo, hi, w))
      SEL_OUTSIDE: res.out_of_grid = 1'b1;
      SEL_INSIDE: begin
        if (it.table_select == SUM_SELECT) begin
          v = blend_table(0, lo, hi, w) + blend_table(1, lo, hi, w);
          if (v > 64'sd2147483647) v = 64'sd2147483647;
          if (v < -64'sd2147483648) v = -64'sd2147483648;
        end else begin
          v = blend_table(it.table_select, lo, hi, w);
        end
        res.interpolated_value = v[31:0];
      end
      default: ;
    endcase
    pending_results.push_back(res);
  endtask

  task automatic send_beat(in_t it);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    apply_item(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_grid(logic [31:0] v [6]);
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 3'(i);
      cfg_data_i <= v[i];
      @(posedge clk_i);
      grid_reg[i] = v[i];
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic in_t load_item(int t, int a, int k, int r, logic [31:0] val);
    in_t it;
    it = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.operation = OP_LOAD;
    it.table_select = 3'(t);
    it.load_alpha_index = 4'(a);
    it.load_k_index = 4'(k);
    it.load_r_index = 4'(r);
    it.load_value = val;
    return it;
  endfunction

  function automatic logic [31:0] aim_coord(int axis, int idx);
    logic [63:0] goal, off;
    logic [31:0] inv;
    inv = grid_reg[2*axis+1];
    if (inv == 0) return grid_reg[2*axis] + $urandom_range(0, 1000);
    goal = {idx[31:0], 16'($urandom), 16'($urandom)};
    if ($urandom_range(0, 5) == 0) goal[31:0] = 32'd0;
    off = (goal + inv - 1) / inv;
    return grid_reg[2*axis] + off[31:0];
  endfunction

  function automatic in_t query_item(int sel, int a, int k, int r);
    in_t it;
    it = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.operation = OP_QUERY;
    it.table_select = 3'(sel);
    it.alpha_coord = aim_coord(0, a);
    it.k_coord = aim_coord(1, k);
    it.r_coord = aim_coord(2, r);
    return it;
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  // load a cell around a base point, then query inside it
  task automatic cell_sequence(int nq);
    int  sel, a, k, r;
    in_t it;
    sel = $urandom_range(0, 5);
    a = ($urandom_range(0, 3) == 0) ? INTERVALS : $urandom_range(0, INTERVALS);
    k = $urandom_range(0, INTERVALS);
    r = ($urandom_range(0, 3) == 0) ? INTERVALS : $urandom_range(0, INTERVALS);
    for (int t = 0; t < 2; t++) begin
      int tt;
      if (t == 1 && sel != SUM_SELECT) break;
      tt = (sel == SUM_SELECT) ? t : sel;
      for (int n = 0; n < 8; n++)
        send_beat(load_item(tt, (a + n[2]) > INTERVALS ? INTERVALS : a + n[2],
                            (k + n[1]) > INTERVALS ? INTERVALS : k + n[1],
                            (r + n[0]) > INTERVALS ? INTERVALS : r + n[0], rand_sample()));
    end
    for (int q = 0; q < nq; q++) begin
      it = query_item(sel, a, k, r);
      for (int tries = 0; tries < 6 && !corners_loaded(it); tries++)
        it = query_item(sel, a, k, r);
      if (!corners_loaded(it)) it.table_select = 3'($urandom_range(6, 7));
      send_beat(it);
    end
  endtask

  task automatic noise_item();
    in_t it;
    it = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    if (!corners_loaded(it)) it.table_select = 3'($urandom_range(6, 7));
    send_beat(it);
  endtask

  task automatic random_mix(int items);
    int start_count;
    start_count = beats_sent;
    while (beats_sent - start_count < items) begin
      if ($urandom_range(0, 6) == 0) begin
        noise_item();
      end else begin
        cell_sequence(4);
      end
    end
  endtask

  task automatic test_directed();
    in_t it;
    for (int t = 0; t < 2; t++)
      for (int n = 0; n < 8; n++)
        send_beat(load_item(t, n[2], n[1], n[0], t ? -32'sd1 << 24 : 32'(n) << 24));
    it = query_item(0, 0, 0, 0);
    it.alpha_coord = 32'h00008000;
    it.k_coord = 32'h0000ffff;
    it.r_coord = 32'h00000000;
    send_beat(it);
    it.table_select = SUM_SELECT;
    send_beat(it);
    send_beat(load_item(0, 15, 15, 15, 32'h7fffffff));
    send_beat(load_item(1, 15, 15, 15, 32'h7fffffff));
    it.alpha_coord = 32'h000f0000;
    it.k_coord = 32'h000f0000;
    it.r_coord = 32'h000f0000;
    send_beat(it);
    send_beat(load_item(0, 15, 15, 15, 32'h80000000));
    send_beat(load_item(1, 15, 15, 15, 32'h80000000));
    send_beat(it);
    it.alpha_coord = 32'hffffffff;
    send_beat(it);
    it.alpha_coord = 32'h00100000;
    send_beat(it);
    it.alpha_coord = 32'h7fffffff;
    it.r_coord = 32'h80000000;
    send_beat(it);
    send_beat(load_item(6, 0, 0, 0, 32'h12345678));
    send_beat(load_item(5, 1, 1, 1, 32'h12345678));
    it.table_select = 3'd7;
    send_beat(it);
    it.table_select = 3'd6;
    send_beat(it);
  endtask

  task automatic test_grid_settings();
    logic [31:0] g [6];
    for (int s = 0; s < 6; s++) begin
      for (int i = 0; i < 3; i++) begin
        case (s)
          0: begin g[2*i] = $urandom_range(0, 32'h00400000) - 32'h00200000;
                   g[2*i+1] = $urandom_range(32'h00004000, 32'h00040000); end
          1: begin g[2*i] = 32'h80000000; g[2*i+1] = 32'hffffffff; end
          2: begin g[2*i] = 32'h7fffffff; g[2*i+1] = 32'd0; end
          3: begin g[2*i] = 32'h80000000; g[2*i+1] = 32'h00000001; end
          4: begin g[2*i] = $urandom; g[2*i+1] = $urandom; end
          default: begin g[2*i] = 32'd0; g[2*i+1] = 32'h00010000; end
        endcase
      end
      set_grid(g);
      random_mix(110);
    end
  endtask

  task automatic test_output_hold();
    drain();
    hold_req = 1'b1;
    idling = 1'b0;
    random_mix(80);
    idling = 1'b1;
  endtask

  task automatic test_full_rate();
    idling = 1'b0;
    random_mix(200);
  endtask

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    grid_reg = '{32'd0, 32'h00010000, 32'd0, 32'h00010000, 32'd0, 32'h00010000};
    test_directed();
    random_mix(150);
    test_grid_settings();
    test_output_hold();
    test_full_rate();
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: trilinear_grid_interpolator_unit.f
src/tgi_pkg.sv
src/tgi_axis.sv
src/tgi_bank.sv
src/tgi_blend.sv
src/tgi_fifo.sv
src/trilinear_grid_interpolator_unit.sv
src/tgi_checker.sv
tb/sv/trilinear_grid_interpolator_unit_test.sv
